### sv/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the postfix stack calculator.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int FUNC_W          = 3;
    localparam int DEPTH_W         = 7;
    localparam int STATUS_W        = 2;
    localparam int S_TDATA_W       = 32;
    localparam int S_TUSER_W       = 3;
    localparam int M_TDATA_W       = 48;

    // Operation codes carried in s_tuser
    localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SUB  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MUL  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DIV  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_NEG  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_POP  = 3'd6;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_FULL    = 2'd2,
        ST_DIVZERO = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DECODE,
        CS_READ,
        CS_EXEC,
        CS_DIV_WAIT,
        CS_FINISH
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    rd_en;
        logic    exec;
        logic    div_start;
        logic    div_load;
        logic    commit;
        status_t status;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              cnt_zero;
        logic              cnt_lt2;
        logic              full;
        logic              top_zero;
        logic              div_done;
    } dp_stat_t;

endpackage

### sv/psc_ram.sv
// ----------------------------------------------------------------------------
// psc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/psc_divider.sv
// ----------------------------------------------------------------------------
// psc_divider
// Signed 32-bit radix-2 restoring divider, truncating toward zero.
// ----------------------------------------------------------------------------
module psc_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [psc_pkg::DATA_W-1:0] dividend,
    input  logic [psc_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [psc_pkg::DATA_W-1:0] quotient
);

    import psc_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [DATA_W:0]  rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]  rem_shift;
    logic [DATA_W:0]  diff;

    // One quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_shift = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W);
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            dvs_next  = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_next = diff;
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    // Restore the sign of the quotient
    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

### sv/psc_datapath.sv
// ----------------------------------------------------------------------------
// psc_datapath
// Stack storage, top-of-stack register, ALU, divider and result register.
// ----------------------------------------------------------------------------
module psc_datapath #(
    parameter int STACK_DEPTH = psc_pkg::STACK_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [psc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [psc_pkg::S_TUSER_W-1:0]  s_tuser,
    input  psc_pkg::dp_cmd_t               cmd,
    output psc_pkg::dp_stat_t              stat,
    output logic [psc_pkg::DATA_W-1:0]     out_top,
    output logic [psc_pkg::DEPTH_W-1:0]    out_depth,
    output psc_pkg::status_t               out_status
);

    import psc_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [FUNC_W-1:0] func_reg;
    logic [DATA_W-1:0] operand_reg;
    logic [DATA_W-1:0] res_reg;
    logic [DATA_W-1:0] out_top_reg;
    logic [DEPTH_W-1:0] out_depth_reg;
    status_t           out_status_reg;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] alu_res;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    logic [CNT_W+DEPTH_W-1:0] depth_wide;

    assign cnt_m1 = count_reg - CNT_W'(1);
    assign cnt_m2 = count_reg - CNT_W'(2);

    // Entries below the top; the top itself lives in top_reg
    psc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_m1[ADDR_W-1:0]),
        .wdata (top_reg),
        .re    (cmd.rd_en),
        .raddr (cnt_m2[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    psc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (ram_rdata),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Arithmetic on second entry (A) and top (B)
    always_comb begin
        case (func_reg)
            FN_ADD:  alu_res = ram_rdata + top_reg;
            FN_SUB:  alu_res = ram_rdata - top_reg;
            FN_MUL:  alu_res = ram_rdata * top_reg;
            default: alu_res = ram_rdata;
        endcase
    end

    // Stack update at commit
    always_comb begin
        top_next   = top_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        if (cmd.commit && (cmd.status == ST_OK)) begin
            case (func_reg)
                FN_PUSH: begin
                    ram_we     = (count_reg != '0);
                    top_next   = operand_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_POP: begin
                    top_next   = res_reg;
                    count_next = cnt_m1;
                end
                FN_NEG: begin
                    top_next = DATA_W'(0) - top_reg;
                end
                default: begin
                    top_next = top_reg;
                end
            endcase
        end
    end

    assign depth_wide = {{DEPTH_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Capture operation, hold intermediate and output payload
    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (cmd.capture) begin
            func_reg    <= s_tuser[FUNC_W-1:0];
            operand_reg <= s_tdata[DATA_W-1:0];
        end
        if (cmd.exec) begin
            res_reg <= alu_res;
        end else if (cmd.div_load) begin
            res_reg <= div_quo;
        end
        if (cmd.commit) begin
            out_top_reg    <= (count_next == '0) ? '0 : top_next;
            out_depth_reg  <= depth_wide[DEPTH_W-1:0];
            out_status_reg <= cmd.status;
        end
    end

    assign stat.func     = func_reg;
    assign stat.cnt_zero = (count_reg == '0);
    assign stat.cnt_lt2  = (count_reg < CNT_W'(2));
    assign stat.full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign stat.top_zero = (top_reg == '0);
    assign stat.div_done = div_done;

    assign out_top    = out_top_reg;
    assign out_depth  = out_depth_reg;
    assign out_status = out_status_reg;

endmodule

### sv/psc_ctrl.sv
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer: decodes each operation, checks it and steps the datapath.
// ----------------------------------------------------------------------------
module psc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  psc_pkg::dp_stat_t  stat,
    output psc_pkg::dp_cmd_t   cmd
);

    import psc_pkg::*;

    ctrl_state_t state_reg, state_next;
    status_t     status_reg, status_next;
    logic        out_valid_reg, out_valid_next;
    status_t     dec_status;
    logic        dec_read;
    logic        out_free;

    // Check operands and choose whether the second entry must be read
    always_comb begin
        dec_status = ST_OK;
        dec_read   = 1'b0;
        case (stat.func)
            FN_PUSH: begin
                if (stat.full) dec_status = ST_FULL;
            end
            FN_ADD, FN_SUB, FN_MUL: begin
                if (stat.cnt_lt2) dec_status = ST_UNDER;
                else              dec_read   = 1'b1;
            end
            FN_DIV: begin
                if (stat.cnt_lt2)       dec_status = ST_UNDER;
                else if (stat.top_zero) dec_status = ST_DIVZERO;
                else                    dec_read   = 1'b1;
            end
            FN_NEG: begin
                if (stat.cnt_zero) dec_status = ST_UNDER;
            end
            FN_POP: begin
                if (stat.cnt_zero) dec_status = ST_UNDER;
                else               dec_read   = 1'b1;
            end
            default: begin
                dec_status = ST_OK;
            end
        endcase
    end

    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            CS_IDLE: begin
                if (s_tvalid) state_next = CS_DECODE;
            end
            CS_DECODE: begin
                status_next = dec_status;
                state_next  = dec_read ? CS_READ : CS_FINISH;
            end
            CS_READ: begin
                state_next = CS_EXEC;
            end
            CS_EXEC: begin
                state_next = (stat.func == FN_DIV) ? CS_DIV_WAIT : CS_FINISH;
            end
            CS_DIV_WAIT: begin
                if (stat.div_done) state_next = CS_FINISH;
            end
            CS_FINISH: begin
                if (out_free) state_next = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd           = '0;
        cmd.status    = status_reg;
        s_tready      = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            CS_DECODE: begin
                cmd.rd_en = dec_read;
            end
            CS_EXEC: begin
                cmd.exec      = (stat.func != FN_DIV);
                cmd.div_start = (stat.func == FN_DIV);
            end
            CS_DIV_WAIT: begin
                cmd.div_load = stat.div_done;
            end
            CS_FINISH: begin
                cmd.commit = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Result valid: set on commit, drop when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CS_IDLE;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

### sv/postfix_stack_calculator_top.sv
// ----------------------------------------------------------------------------
// postfix_stack_calculator_top
// Postfix integer stack calculator on stream channels.
// ----------------------------------------------------------------------------
// Each input transaction is one operation: s_tuser selects push, add,
// subtract, multiply, divide, negate or pop, and s_tdata carries the value
// for a push. Each operation returns exactly one output transaction with the
// new top of stack (zero when empty), the depth and a status code.
// Underflow, push onto a full stack and divide by zero are reported in the
// status and leave the stack unchanged.
// Push, negate and rejected operations go from decode straight to commit;
// add, subtract, multiply and pop first read the second entry and execute, and
// divide then waits for the radix-2 divider, which produces one quotient bit
// per cycle. One operation is in flight at a time; the next is accepted in the
// cycle after the previous result is loaded into the output register, even while
// that result still waits for the receiver. A stalled receiver holds the finished
// result and blocks only the commit of the following operation.
// Reset empties the stack; stack memory contents are not cleared.
// ----------------------------------------------------------------------------
module postfix_stack_calculator_top #(
    parameter int STACK_DEPTH = psc_pkg::STACK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [psc_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] operand
    input  logic [psc_pkg::S_TUSER_W-1:0] s_tuser,   // [2:0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psc_pkg::M_TDATA_W-1:0] m_tdata    // [31:0] top_value,
                                                     // [38:32] stack_depth,
                                                     // [40:39] status, zero pad
);

    import psc_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [DATA_W-1:0]  out_top;
    logic [DEPTH_W-1:0] out_depth;
    status_t            out_status;

    psc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    psc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cmd        (cmd),
        .stat       (stat),
        .out_top    (out_top),
        .out_depth  (out_depth),
        .out_status (out_status)
    );

    // Pack result fields from the lowest bit up
    assign m_tdata = {
        (M_TDATA_W - DATA_W - DEPTH_W - STATUS_W)'(0),
        out_status,
        out_depth,
        out_top
    };

endmodule

### sim/tb_postfix_stack_calculator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_postfix_stack_calculator_top
// Self-checking testbench for the postfix stack calculator.
// ----------------------------------------------------------------------------
// Operations go in on the s_ channel and results come back on the m_ channel.
// A behavioral stack in the testbench computes the expected top, depth and
// status of every accepted operation. The checker compares each output
// transaction with the oldest pending expectation. Directed tests cover
// the empty and full stack, wraparound and the divide corners. Random
// expression streams with some noise follow. Both channels idle in bursts
// except in the last phase.
// ----------------------------------------------------------------------------
module tb_postfix_stack_calculator_top;
    import psc_pkg::*;

    localparam int          CALC_DEPTH     = STACK_DEPTH_DEF;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          TAIL_CYCLES    = 50;
    // Code 7 has no operation behind it; the block must leave the stack alone
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
        status_t            status;
    } calc_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Behavioral stack
    logic [DATA_W-1:0] calc_stack [CALC_DEPTH];
    int                calc_depth = 0;

    calc_result_t pending_results [$];
    bit           idle_on      = 1'b1;
    int           rx_stall     = 0;
    int           quiet_cycles = 0;
    int           n_errors     = 0;
    int           n_sent       = 0;
    int           n_checked    = 0;
    int           status_seen [4] = '{0, 0, 0, 0};

    postfix_stack_calculator_top #(
        .STACK_DEPTH(CALC_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Signed divide truncating toward zero, done on magnitudes
    function automatic logic [DATA_W-1:0] trunc_quotient(input logic [DATA_W-1:0] num,
                                                         input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] q;
        mag_n = num[DATA_W-1] ? (32'd0 - num) : num;
        mag_d = den[DATA_W-1] ? (32'd0 - den) : den;
        q     = mag_n / mag_d;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? (32'd0 - q) : q;
    endfunction

    // Apply one operation to the behavioral stack and return the expected result
    function automatic calc_result_t calc_apply(input logic [FUNC_W-1:0] fn,
                                                input logic [DATA_W-1:0] opnd);
        calc_result_t      res;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] val;
        res.status = ST_OK;
        val        = '0;
        case (fn)
            FN_PUSH: begin
                if (calc_depth >= CALC_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    calc_stack[calc_depth] = opnd;
                    calc_depth++;
                end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
                if (calc_depth < 2) begin
                    res.status = ST_UNDER;
                end else begin
                    rhs = calc_stack[calc_depth-1];
                    lhs = calc_stack[calc_depth-2];
                    case (fn)
                        FN_ADD:  val = lhs + rhs;
                        FN_SUB:  val = lhs - rhs;
                        FN_MUL:  val = lhs * rhs;
                        default: begin
                            if (rhs == '0) res.status = ST_DIVZERO;
                            else           val = trunc_quotient(lhs, rhs);
                        end
                    endcase
                    if (res.status == ST_OK) begin
                        calc_depth--;
                        calc_stack[calc_depth-1] = val;
                    end
                end
            end
            FN_NEG: begin
                if (calc_depth < 1) res.status = ST_UNDER;
                else calc_stack[calc_depth-1] = 32'd0 - calc_stack[calc_depth-1];
            end
            FN_POP: begin
                if (calc_depth < 1) res.status = ST_UNDER;
                else calc_depth--;
            end
            default: ;
        endcase
        res.top   = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
        res.depth = DEPTH_W'(calc_depth);
        return res;
    endfunction

    // Operand mix: corners, zero and small values for divides, full random
    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_ffff;
            3:       return 32'hffff_ffff;
            4, 5:    return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    // Send one operation, with an optional idle burst ahead of it
    task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] opnd);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= opnd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(calc_apply(fn, opnd));
        n_sent++;
    endtask

    // Hold the sender until every pending result has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Every operation on an empty stack, then wraparound and divide corners
    task automatic test_directed();
        send_op(FN_ADD, 32'h0);
        send_op(FN_SUB, 32'hffff_ffff);
        send_op(FN_MUL, 32'h0);
        send_op(FN_DIV, 32'h0);
        send_op(FN_NEG, 32'h0);
        send_op(FN_POP, 32'h0);
        send_op(FN_UNUSED, 32'hffff_ffff);
        // max + 1 wraps to the most negative value
        send_op(FN_PUSH, 32'h7fff_ffff);
        send_op(FN_PUSH, 32'h0000_0001);
        send_op(FN_ADD, 32'h0);
        // most negative / -1 wraps to itself
        send_op(FN_PUSH, 32'hffff_ffff);
        send_op(FN_DIV, 32'h0);
        send_op(FN_PUSH, 32'h0000_0000);
        send_op(FN_DIV, 32'h0);
        send_op(FN_POP, 32'h0);
        // -7 / 2 truncates to -3
        send_op(FN_PUSH, 32'hffff_fff9);
        send_op(FN_PUSH, 32'h0000_0002);
        send_op(FN_DIV, 32'h0);
        send_op(FN_SUB, 32'h0);
        send_op(FN_PUSH, 32'h0001_0001);
        send_op(FN_MUL, 32'h0);
        send_op(FN_NEG, 32'h0);
        send_op(FN_ADD, 32'h0);
        send_op(FN_POP, 32'h0);
        send_op(FN_POP, 32'h0);
        drain();
    endtask

    // Fill the stack, push past the end, then unwind below empty
    task automatic test_full_stack();
        while (calc_depth > 0) send_op(FN_POP, $urandom);
        while (calc_depth < CALC_DEPTH) send_op(FN_PUSH, rand_operand());
        send_op(FN_PUSH, $urandom);
        send_op(FN_PUSH, 32'h7fff_ffff);
        send_op(FN_NEG, $urandom);
        send_op(FN_ADD, $urandom);
        send_op(FN_PUSH, 32'h8000_0000);
        while (calc_depth > 0) send_op(FN_POP, $urandom);
        send_op(FN_POP, $urandom);
        drain();
    endtask

    // Random expression streams with some noise mixed in
    task automatic test_random_programs(input int n_ops);
        int                r;
        logic [FUNC_W-1:0] fn;
        for (int i = 0; i < n_ops; i++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                send_op(FUNC_W'($urandom_range(0, 7)), $urandom);
            end else if (calc_depth == 0 || (r < 56 && calc_depth < CALC_DEPTH - 16)) begin
                send_op(FN_PUSH, rand_operand());
            end else begin
                case ($urandom_range(0, 9))
                    0, 1:    fn = FN_ADD;
                    2, 3:    fn = FN_SUB;
                    4, 5:    fn = FN_MUL;
                    6, 7:    fn = FN_DIV;
                    8:       fn = FN_NEG;
                    default: fn = FN_POP;
                endcase
                send_op(fn, $urandom);
            end
        end
        drain();
    endtask

    // Back-to-back traffic with both channels always ready
    task automatic test_no_idle(input int n_ops);
        idle_on = 1'b0;
        test_random_programs(n_ops);
    endtask

    // Receiver stalls in bursts, only while idle bursts are enabled
    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_stall = $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each output transaction with the oldest expectation
    always @(posedge aclk) begin : check_results
        calc_result_t want;
        calc_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.top    = m_tdata[31:0];
            got.depth  = m_tdata[38:32];
            got.status = status_t'(m_tdata[40:39]);
            status_seen[got.status]++;
            n_checked++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: top %h depth %0d status %0d",
                       got.top, got.depth, got.status);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.top !== want.top) begin
                    $error("top_value: expected %h, actual %h", want.top, got.top);
                    n_errors++;
                end
                if (got.depth !== want.depth) begin
                    $error("stack_depth: expected %0d, actual %0d", want.depth, got.depth);
                    n_errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    n_errors++;
                end
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_full_stack();
        test_random_programs(580);
        test_no_idle(100);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            n_errors++;
        end

        $display("Checked %0d results for %0d operations: ok %0d, underflow %0d, full %0d, div0 %0d",
                 n_checked, n_sent, status_seen[ST_OK], status_seen[ST_UNDER],
                 status_seen[ST_FULL], status_seen[ST_DIVZERO]);
        $display("Covered empty and full stack, wraparound, divide corners and stalls both sides");
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### postfix_stack_calculator_top.f
sv/psc_pkg.sv
sv/psc_ram.sv
sv/psc_divider.sv
sv/psc_datapath.sv
sv/psc_ctrl.sv
sv/postfix_stack_calculator_top.sv
sim/tb_postfix_stack_calculator_top.sv
